>>> rtl/dqts_pkg.sv
package dqts_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int ID_W       = $clog2(SLOT_COUNT + 1);
  localparam logic [ID_W-1:0] NONE_ID = ID_W'(SLOT_COUNT);

  // command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_DISP = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NODEL   = 3'd3;
  localparam logic [2:0] ST_NODUE   = 3'd4;
  localparam logic [2:0] ST_SKIPPED = 3'd5;

  // sticky error codes
  localparam logic [1:0] ERR_NULL  = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_NODEL = 2'd3;

  typedef logic alu_op_t;
  localparam alu_op_t ALU_SUB  = 1'b0;
  localparam alu_op_t ALU_ADDS = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_id;
    logic [31:0] run_tag;
    logic        run_now;
    logic        last;
    logic [1:0]  sticky_error;
    logic [31:0] uptime_ticks;
  } out_item_t;

endpackage

>>> rtl/dqts_alu.sv
module dqts_alu import dqts_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res,
  output logic        gt,
  output logic        borrow
);

  logic [32:0] sum;
  logic [32:0] diff;

  // one adder and one subtractor shared by the tick, insert-walk and fix steps
  assign sum    = {1'b0, a} + {1'b0, b};
  assign diff   = {1'b0, a} - {1'b0, b};
  assign borrow = diff[32];
  assign gt     = !diff[32] && (diff[31:0] != 32'd0);

  // saturate on carry out of the add
  always_comb begin
    if (op == ALU_ADDS) begin
      res = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else begin
      res = diff[31:0];
    end
  end

endmodule

>>> rtl/dqts_out.sv
module dqts_out import dqts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t item_in,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t item_q,
  output logic      free
);

  logic      valid_r;
  out_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign item_q    = item_r;

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

endmodule

>>> rtl/delta_queue_task_scheduler.sv
// Delta-queue task scheduler.
// Input channel (in_valid/in_ready) takes one command transaction: add, delete,
// tick or dispatch. Result channel (out_valid/out_ready) returns one result per
// add, delete and tick, and one per due slot on dispatch (a single "nothing
// due" result when none is due); out_last marks the final result of a command.
// in_ready is high only while the sequencer is idle; one command is in work at
// a time. The sequencer walks the linked delta queue one entry per cycle with a
// shared 32-bit add/subtract unit. An add or a periodic reinsert walks the
// queue to remove the slot and again to insert it, and a delete walks it once.
// A tick moves one matured slot to the due list per cycle; a dispatch pops one
// one-shot slot per cycle while the result register is free, plus a walk per
// periodic slot.
// The result register lets the next command be accepted while a result waits.
// If the receiver stalls, the sequencer halts before writing the next result.
// Synchronous reset empties every slot, both lists, the uptime and the error.
module delta_queue_task_scheduler import dqts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_task_tag,
  input  logic [31:0] in_delay_ticks,
  input  logic [31:0] in_period_ticks,
  input  logic [7:0]  in_slot_to_delete,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot_id,
  output logic [31:0] out_run_tag,
  output logic        out_run_now,
  output logic        out_last,
  output logic [1:0]  out_sticky_error,
  output logic [31:0] out_uptime_ticks
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD      = 4'd1;
  localparam logic [3:0] S_DEL      = 4'd2;
  localparam logic [3:0] S_TICK     = 4'd3;
  localparam logic [3:0] S_TK_POP   = 4'd4;
  localparam logic [3:0] S_DISP     = 4'd5;
  localparam logic [3:0] S_DISP_POP = 4'd6;
  localparam logic [3:0] S_RM_START = 4'd7;
  localparam logic [3:0] S_RM_WALK  = 4'd8;
  localparam logic [3:0] S_RM_FIX   = 4'd9;
  localparam logic [3:0] S_INS_WALK = 4'd10;
  localparam logic [3:0] S_INS_FIX  = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0] state_r;

  // slot storage
  logic [31:0]     slot_tag_r    [SLOT_COUNT];
  logic [31:0]     slot_period_r [SLOT_COUNT];
  logic [31:0]     rel_delay_r   [SLOT_COUNT];
  logic [ID_W-1:0] queue_link_r  [SLOT_COUNT];
  logic [ID_W-1:0] due_link_r    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_used_r;
  logic [SLOT_COUNT-1:0] on_due_r;
  logic [ID_W-1:0] queue_head_r;
  logic [ID_W-1:0] due_head_r;
  logic [31:0]     tick_count_r;
  logic [1:0]      error_latch_r;

  // command registers
  logic [31:0]     tag_r;
  logic [31:0]     delay_in_r;
  logic [31:0]     period_in_r;
  logic [7:0]      del_r;

  // walk registers
  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] cur_r;
  logic [ID_W-1:0] prev_r;
  logic [ID_W-1:0] nxt_r;
  logic [31:0]     dly_r;
  logic [31:0]     dcur_r;
  logic            ins_r;
  logic            disp_r;
  logic [2:0]      res_status_r;
  logic [ID_W-1:0] res_slot_r;

  // shared unit
  alu_op_t         alu_op;
  logic [31:0]     alu_a;
  logic [31:0]     alu_b;
  logic [31:0]     alu_res;
  logic            alu_gt;
  logic            alu_borrow;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] lk_idx;
  logic [31:0]      rd_val;
  logic [ID_W-1:0]  lk_val;

  logic [ID_W-1:0]  free_id;
  logic             free_found;
  logic             cur_ok;
  logic             head_ok;
  logic             due_ok;
  logic [IDX_W-1:0] due_idx;

  logic            out_free;
  logic            out_load;
  out_item_t       out_item;
  out_item_t       out_q;

  assign in_ready = (state_r == S_IDLE);
  assign cur_ok   = (cur_r < NONE_ID);
  assign head_ok  = (queue_head_r < NONE_ID);
  assign due_ok   = (due_head_r < NONE_ID);
  assign due_idx  = due_head_r[IDX_W-1:0];

  // first free slot
  always_comb begin
    free_id    = NONE_ID;
    free_found = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_found && !slot_used_r[i]) begin
        free_id    = ID_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // one read port each on delays and links
  always_comb begin
    case (state_r)
      S_TICK, S_TK_POP: rd_idx = queue_head_r[IDX_W-1:0];
      S_RM_FIX:         rd_idx = nxt_r[IDX_W-1:0];
      default:          rd_idx = cur_r[IDX_W-1:0];
    endcase
    if (state_r == S_TK_POP) begin
      lk_idx = queue_head_r[IDX_W-1:0];
    end else begin
      lk_idx = cur_r[IDX_W-1:0];
    end
  end

  assign rd_val = rel_delay_r[rd_idx];
  assign lk_val = queue_link_r[lk_idx];

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = 32'd0;
    alu_b  = 32'd0;
    case (state_r)
      S_TICK: begin
        alu_a = rd_val;
        alu_b = 32'd1;
      end
      S_INS_WALK: begin
        alu_a = dly_r;
        alu_b = rd_val;
      end
      S_RM_FIX: begin
        alu_op = ALU_ADDS;
        alu_a  = rd_val;
        alu_b  = dcur_r;
      end
      S_INS_FIX: begin
        alu_a = rd_val;
        alu_b = dly_r;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  dqts_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .gt     (alu_gt),
    .borrow (alu_borrow)
  );

  // result to load into the output register
  always_comb begin
    out_load = 1'b0;
    out_item = '0;
    out_item.sticky_error = error_latch_r;
    out_item.uptime_ticks = tick_count_r;
    if (state_r == S_EMIT) begin
      out_load         = out_free;
      out_item.status  = res_status_r;
      out_item.slot_id = 5'(res_slot_r);
      out_item.last    = 1'b1;
    end else if (state_r == S_DISP_POP && due_ok) begin
      out_load         = out_free;
      out_item.slot_id = 5'(due_head_r);
      out_item.last    = (due_link_r[due_idx] == NONE_ID);
      if (slot_used_r[due_idx]) begin
        out_item.status  = ST_OK;
        out_item.run_tag = slot_tag_r[due_idx];
        out_item.run_now = 1'b1;
      end else begin
        out_item.status = ST_SKIPPED;
      end
    end
  end

  dqts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .item_in   (out_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .item_q    (out_q),
    .free      (out_free)
  );

  assign out_status       = out_q.status;
  assign out_slot_id      = out_q.slot_id;
  assign out_run_tag      = out_q.run_tag;
  assign out_run_now      = out_q.run_now;
  assign out_last         = out_q.last;
  assign out_sticky_error = out_q.sticky_error;
  assign out_uptime_ticks = out_q.uptime_ticks;

  // sequencer and storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_used_r   <= '0;
      on_due_r      <= '0;
      queue_head_r  <= NONE_ID;
      due_head_r    <= NONE_ID;
      tick_count_r  <= 32'd0;
      error_latch_r <= 2'd0;
      ins_r         <= 1'b0;
      disp_r        <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_tag_r[i]    <= 32'd0;
        slot_period_r[i] <= 32'd0;
        rel_delay_r[i]   <= 32'd0;
        queue_link_r[i]  <= NONE_ID;
        due_link_r[i]    <= NONE_ID;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tag_r       <= in_task_tag;
            delay_in_r  <= in_delay_ticks;
            period_in_r <= in_period_ticks;
            del_r       <= in_slot_to_delete;
            disp_r      <= 1'b0;
            case (in_command)
              CMD_ADD:  state_r <= S_ADD;
              CMD_DEL:  state_r <= S_DEL;
              CMD_TICK: state_r <= S_TICK;
              CMD_DISP: state_r <= S_DISP;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (tag_r == 32'd0) begin
            error_latch_r <= ERR_NULL;
            res_status_r  <= ST_NULL;
            res_slot_r    <= NONE_ID;
            state_r       <= S_EMIT;
          end else if (!free_found) begin
            error_latch_r <= ERR_FULL;
            res_status_r  <= ST_FULL;
            res_slot_r    <= NONE_ID;
            state_r       <= S_EMIT;
          end else begin
            slot_tag_r[free_id[IDX_W-1:0]]    <= tag_r;
            slot_period_r[free_id[IDX_W-1:0]] <= period_in_r;
            slot_used_r[free_id[IDX_W-1:0]]   <= 1'b1;
            id_r         <= free_id;
            dly_r        <= delay_in_r;
            ins_r        <= 1'b1;
            res_status_r <= ST_OK;
            res_slot_r   <= free_id;
            state_r      <= S_RM_START;
          end
        end
        S_DEL: begin
          if ({1'b0, del_r} >= 9'(SLOT_COUNT) || !slot_used_r[del_r[IDX_W-1:0]]) begin
            error_latch_r <= ERR_NODEL;
            res_status_r  <= ST_NODEL;
            res_slot_r    <= NONE_ID;
            state_r       <= S_EMIT;
          end else begin
            slot_tag_r[del_r[IDX_W-1:0]]    <= 32'd0;
            slot_period_r[del_r[IDX_W-1:0]] <= 32'd0;
            slot_used_r[del_r[IDX_W-1:0]]   <= 1'b0;
            id_r         <= ID_W'(del_r[IDX_W-1:0]);
            ins_r        <= 1'b0;
            res_status_r <= ST_OK;
            res_slot_r   <= ID_W'(del_r[IDX_W-1:0]);
            state_r      <= S_RM_START;
          end
        end
        S_TICK: begin
          // count and decrement the head delay, floor at zero
          tick_count_r <= tick_count_r + 32'd1;
          if (head_ok && !alu_borrow) begin
            rel_delay_r[rd_idx] <= alu_res;
          end
          state_r <= S_TK_POP;
        end
        S_TK_POP: begin
          // move one matured head to the due list per cycle
          if (head_ok && rd_val == 32'd0) begin
            queue_head_r         <= lk_val;
            queue_link_r[lk_idx] <= NONE_ID;
            if (!on_due_r[lk_idx]) begin
              due_link_r[lk_idx] <= due_head_r;
              due_head_r         <= queue_head_r;
              on_due_r[lk_idx]   <= 1'b1;
            end
          end else begin
            res_status_r <= ST_OK;
            res_slot_r   <= NONE_ID;
            state_r      <= S_EMIT;
          end
        end
        S_DISP: begin
          disp_r <= 1'b1;
          if (!due_ok) begin
            res_status_r <= ST_NODUE;
            res_slot_r   <= NONE_ID;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_DISP_POP;
          end
        end
        S_DISP_POP: begin
          if (!due_ok) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            // pop one due slot and retire or requeue it
            due_head_r          <= due_link_r[due_idx];
            due_link_r[due_idx] <= NONE_ID;
            on_due_r[due_idx]   <= 1'b0;
            if (slot_used_r[due_idx]) begin
              if (slot_period_r[due_idx] != 32'd0) begin
                id_r    <= due_head_r;
                dly_r   <= slot_period_r[due_idx];
                ins_r   <= 1'b1;
                state_r <= S_RM_START;
              end else begin
                slot_used_r[due_idx]   <= 1'b0;
                slot_tag_r[due_idx]    <= 32'd0;
                slot_period_r[due_idx] <= 32'd0;
              end
            end
          end
        end
        S_RM_START: begin
          cur_r   <= queue_head_r;
          prev_r  <= NONE_ID;
          state_r <= S_RM_WALK;
        end
        S_RM_WALK: begin
          if (!cur_ok) begin
            if (ins_r) begin
              cur_r   <= queue_head_r;
              prev_r  <= NONE_ID;
              state_r <= S_INS_WALK;
            end else begin
              state_r <= S_EMIT;
            end
          end else if (cur_r == id_r) begin
            // unlink and carry the delay to the successor
            if (prev_r < NONE_ID) begin
              queue_link_r[prev_r[IDX_W-1:0]] <= lk_val;
            end else begin
              queue_head_r <= lk_val;
            end
            queue_link_r[lk_idx] <= NONE_ID;
            rel_delay_r[rd_idx]  <= 32'd0;
            dcur_r  <= rd_val;
            nxt_r   <= lk_val;
            state_r <= S_RM_FIX;
          end else begin
            prev_r <= cur_r;
            cur_r  <= lk_val;
          end
        end
        S_RM_FIX: begin
          if (nxt_r < NONE_ID) begin
            rel_delay_r[rd_idx] <= alu_res;
          end
          if (ins_r) begin
            cur_r   <= queue_head_r;
            prev_r  <= NONE_ID;
            state_r <= S_INS_WALK;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_INS_WALK: begin
          if (cur_ok && alu_gt) begin
            dly_r  <= alu_res;
            prev_r <= cur_r;
            cur_r  <= lk_val;
          end else begin
            // link in ahead of the current entry
            rel_delay_r[id_r[IDX_W-1:0]]  <= dly_r;
            queue_link_r[id_r[IDX_W-1:0]] <= cur_r;
            if (prev_r < NONE_ID) begin
              queue_link_r[prev_r[IDX_W-1:0]] <= id_r;
            end else begin
              queue_head_r <= id_r;
            end
            state_r <= S_INS_FIX;
          end
        end
        S_INS_FIX: begin
          if (cur_ok) begin
            rel_delay_r[rd_idx] <= alu_res;
          end
          ins_r <= 1'b0;
          if (disp_r) begin
            state_r <= S_DISP_POP;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/dqts_checker.sv
module dqts_checker import dqts_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [4:0]  out_slot_id,
  input logic [31:0] out_run_tag,
  input logic        out_run_now
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_id) && $stable(out_status))
    else $error("result changed while stalled");

  // one command in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a command while busy");

  // only successful dispatch results run a task
  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_now |-> out_status == ST_OK && out_run_tag != 32'd0)
    else $error("run result with bad status or null tag");

  // skipped results never run
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SKIPPED |-> !out_run_now && out_run_tag == 32'd0)
    else $error("skipped slot marked to run");

endmodule

bind delta_queue_task_scheduler dqts_checker u_dqts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_slot_id (out_slot_id),
  .out_run_tag (out_run_tag),
  .out_run_now (out_run_now)
);
